// ----- src/pushbuffer_command_decoder_top_assert.svh -----
// Assertion macros for the pushbuffer command decoder checker.
`ifndef PUSHBUFFER_COMMAND_DECODER_TOP_ASSERT_SVH
`define PUSHBUFFER_COMMAND_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pushbuffer command decoder assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pushbuffer command decoder assertion failed");

`endif

// ----- src/pcd_pkg.sv -----
// Types and constants of the pushbuffer command decoder.
package pcd_pkg;

   // Field widths of the command and result transactions.
   localparam int WordWidth  = 32;
   localparam int LeftWidth  = 12;
   localparam int AddrWidth  = 13;
   localparam int CountWidth = 11;
   localparam int KindWidth  = 3;
   localparam int ReqWidth   = 48;
   localparam int RspWidth   = 104;

   // Result kinds, carried on rsp_tuser.
   localparam logic [KindWidth-1:0] KIND_JUMP      = 3'd0;
   localparam logic [KindWidth-1:0] KIND_METHOD    = 3'd1;
   localparam logic [KindWidth-1:0] KIND_PARAM     = 3'd2;
   localparam logic [KindWidth-1:0] KIND_BAD       = 3'd3;
   localparam logic [KindWidth-1:0] KIND_TRUNCATED = 3'd4;

   // Header prefixes in bits 31 to 30.
   localparam logic [1:0] PREFIX_INCREMENT     = 2'b00;
   localparam logic [1:0] PREFIX_NON_INCREMENT = 2'b10;

   // Bit positions within a header word.
   localparam int JumpBit       = 0;
   localparam int NonIncBit     = 29;
   localparam int PrefixLsb     = 30;
   localparam int CountLsb      = 18;
   localparam int MethodLsb     = 2;

   // One decoded result.
   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic [WordWidth-1:0]  jump_dest;
      logic [AddrWidth-1:0]  method_addr;
      logic [CountWidth-1:0] word_count;
      logic                  non_increment;
      logic [WordWidth-1:0]  param_data;
      logic [CountWidth-1:0] param_index;
      logic                  packet_end;
   } result_type;

endpackage

// ----- src/pushbuffer_command_decoder_top.sv -----
// Pushbuffer command decoder: splits a command word stream into headers and payload.
//
// Channel   Direction  tdata (low bit up)                         tuser / tlast
// req_      in         data_word[31:0], words_left[43:32]          -
// rsp_      out        jump_dest, method_addr, word_count,         kind / packet_end
//                      non_increment, param_data, param_index
//
// One command word is taken per cycle while the result side is not stalled; its result
// passes through the input register and then the result register, around the decode
// logic, before it is offered on rsp_.
// Reset is synchronous and active high; it clears both valid flags and the packet state.
// A stalled result holds the result register; the input register keeps filling
// until it too is occupied, so req_tready drops only when both stages are full.
module pushbuffer_command_decoder_top
   import pcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // data_word[31:0], words_left[43:32], zero fill[47:44]
   input  logic [ReqWidth-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // jump_dest[31:0], method_addr[44:32], word_count[55:45], non_increment[56],
   // param_data[88:57], param_index[99:89], zero fill[103:100]
   output logic [RspWidth-1:0] rsp_tdata,
   // kind[2:0]
   output logic [KindWidth-1:0] rsp_tuser,
   output logic                rsp_tlast
);

   // Input register stage.
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [WordWidth-1:0]  in_word_ff;
   logic [LeftWidth-1:0]  in_left_ff;

   // Result register stage.
   logic                  out_valid_ff;
   logic                  out_valid_in;
   result_type            out_result_ff;
   result_type            result;

   // Packet state.
   logic [CountWidth-1:0] pending_ff;
   logic [CountWidth-1:0] pending_in;
   logic [CountWidth-1:0] held_method_ff;
   logic [CountWidth-1:0] held_method_in;
   logic                  held_ninc_ff;
   logic                  held_ninc_in;
   logic [CountWidth-1:0] next_index_ff;
   logic [CountWidth-1:0] next_index_in;

   // Header fields.
   logic [1:0]            prefix;
   logic [CountWidth-1:0] count;
   logic                  ninc;
   logic                  advance;

   // A word moves into the result register when that register is free or being emptied.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_tready);

   assign prefix = in_word_ff[PrefixLsb +: 2];
   assign count  = in_word_ff[CountLsb +: CountWidth];
   assign ninc   = (prefix == PREFIX_NON_INCREMENT) || in_word_ff[NonIncBit];

   // Decode the registered word against the packet state.
   always_comb begin
      result         = '0;
      pending_in     = pending_ff;
      held_method_in = held_method_ff;
      held_ninc_in   = held_ninc_ff;
      next_index_in  = next_index_ff;
      if (pending_ff != '0) begin
         // Inside a packet every word is a parameter word.
         result.kind          = KIND_PARAM;
         result.method_addr   = {held_method_ff, 2'b00};
         result.non_increment = held_ninc_ff;
         result.param_data    = in_word_ff;
         result.param_index   = next_index_ff;
         result.packet_end    = (pending_ff == CountWidth'(1));
         pending_in           = pending_ff - CountWidth'(1);
         next_index_in        = next_index_ff + CountWidth'(1);
      end else if (in_word_ff[JumpBit]) begin
         result.kind        = KIND_JUMP;
         result.jump_dest   = {in_word_ff[WordWidth-1:2], 2'b00};
         result.packet_end  = 1'b1;
      end else if (prefix != PREFIX_INCREMENT && prefix != PREFIX_NON_INCREMENT) begin
         result.kind       = KIND_BAD;
         result.packet_end = 1'b1;
      end else begin
         result.method_addr   = {in_word_ff[MethodLsb +: CountWidth], 2'b00};
         result.word_count    = count;
         result.non_increment = ninc;
         if ({1'b0, count} + LeftWidth'(1) > in_left_ff) begin
            // The header promises more words than the stream holds.
            result.kind       = KIND_TRUNCATED;
            result.packet_end = 1'b1;
         end else begin
            result.kind       = KIND_METHOD;
            result.packet_end = (count == '0);
            pending_in        = count;
            held_method_in    = in_word_ff[MethodLsb +: CountWidth];
            held_ninc_in      = ninc;
            next_index_in     = '0;
         end
      end
   end

   // Control and packet state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         pending_ff     <= '0;
         held_method_ff <= '0;
         held_ninc_ff   <= 1'b0;
         next_index_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pending_ff     <= pending_in;
            held_method_ff <= held_method_in;
            held_ninc_ff   <= held_ninc_in;
            next_index_ff  <= next_index_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_word_ff <= req_tdata[WordWidth-1:0];
         in_left_ff <= req_tdata[WordWidth +: LeftWidth];
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   // Pack the result transaction.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.kind;
   assign rsp_tlast  = out_result_ff.packet_end;
   assign rsp_tdata  = {4'b0000,
                        out_result_ff.param_index,
                        out_result_ff.param_data,
                        out_result_ff.non_increment,
                        out_result_ff.word_count,
                        out_result_ff.method_addr,
                        out_result_ff.jump_dest};

endmodule

// ----- src/pcd_checker.sv -----
// Port-level checker for the pushbuffer command decoder, with its bind.
`include "pushbuffer_command_decoder_top_assert.svh"

module pcd_checker
   import pcd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RspWidth-1:0]  rsp_tdata,
   input logic [KindWidth-1:0] rsp_tuser,
   input logic                 rsp_tlast
);

   logic jump_or_error;
   logic param_zero;

   assign jump_or_error = (rsp_tuser == KIND_JUMP) || (rsp_tuser == KIND_BAD)
                          || (rsp_tuser == KIND_TRUNCATED);
   assign param_zero    = (rsp_tdata[88:57] == '0) && (rsp_tdata[99:89] == '0);

   // A stalled result transaction stays put.
   `PCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Jumps and errors always close their packet.
   `PCD_ASSERT_NOW(a_end_on_jump_error, clock, reset, rsp_tvalid && jump_or_error, rsp_tlast)

   // Only parameter words carry payload data and an index.
   `PCD_ASSERT_NOW(a_param_fields, clock, reset, rsp_tvalid && (rsp_tuser != KIND_PARAM), param_zero)

   // With the result side blocked and both stages full, no further command is taken while rsp_tready stays low.
   `PCD_ASSERT_NEXT(a_full_stall, clock, reset, rsp_tvalid && !rsp_tready && !req_tready, !req_tready || rsp_tready)

endmodule

bind pushbuffer_command_decoder_top pcd_checker u_pcd_checker (.*);

// ----- test/tb.sv -----
// Self-checking testbench for the pushbuffer command decoder.
`timescale 1ns / 1ps

module tb
   import pcd_pkg::*;
();

   // One command word with the stream words available from it on.
   typedef struct {
      logic [WordWidth-1:0] word;
      logic [LeftWidth-1:0] left;
      bit                   drain_first;
   } command_item_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ReqWidth-1:0]  req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RspWidth-1:0]  rsp_tdata;
   logic [KindWidth-1:0] rsp_tuser;
   logic                 rsp_tlast;

   command_item_type pending_commands[$];
   result_type       expected_results[$];
   int               error_count = 0;

   // Decoder state as the predictor sees it.
   logic [CountWidth-1:0] words_owed = '0;
   logic [CountWidth-1:0] packet_method = '0;
   logic                  packet_non_inc = 1'b0;
   logic [CountWidth-1:0] param_position = '0;

   // Sender burst shaping.
   int burst_left = 1;
   int gap_left = 0;

   // Receiver stall pattern.
   int  stall_mode = 0;
   int  mode_left = 0;
   int  hold_left = 0;
   int  tick = 0;
   int  results_taken = 0;
   bit  long_hold_done = 1'b0;

   pushbuffer_command_decoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Works out the result of one command word and advances the packet state.
   function automatic result_type decode_command(input logic [WordWidth-1:0] w,
                                                 input logic [LeftWidth-1:0] avail);
      result_type            r;
      logic [1:0]            prefix;
      logic [CountWidth-1:0] count;
      r = '0;
      prefix = w[PrefixLsb +: 2];
      count = w[CountLsb +: CountWidth];
      if (words_owed != '0) begin
         // Inside a packet every word is payload, whatever its bits.
         r.kind = KIND_PARAM;
         r.method_addr = {packet_method, 2'b00};
         r.non_increment = packet_non_inc;
         r.param_data = w;
         r.param_index = param_position;
         r.packet_end = (words_owed == 11'd1);
         words_owed = words_owed - 11'd1;
         param_position = param_position + 11'd1;
      end else if (w[JumpBit]) begin
         r.kind = KIND_JUMP;
         r.jump_dest = {w[WordWidth-1:2], 2'b00};
         r.packet_end = 1'b1;
      end else if (prefix != PREFIX_INCREMENT && prefix != PREFIX_NON_INCREMENT) begin
         r.kind = KIND_BAD;
         r.packet_end = 1'b1;
      end else begin
         r.method_addr = {w[MethodLsb +: CountWidth], 2'b00};
         r.word_count = count;
         r.non_increment = (prefix == PREFIX_NON_INCREMENT) || w[NonIncBit];
         if ({1'b0, count} + 12'd1 > avail) begin
            r.kind = KIND_TRUNCATED;
            r.packet_end = 1'b1;
         end else begin
            r.kind = KIND_METHOD;
            r.packet_end = (count == '0);
            words_owed = count;
            packet_method = w[MethodLsb +: CountWidth];
            packet_non_inc = r.non_increment;
            param_position = '0;
         end
      end
      return r;
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got 0x%08h, expected 0x%08h", what, got, want);
      error_count++;
   endtask

   // Driver: presents queued commands in bursts and predicts each accepted transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         words_owed = '0;
         packet_method = '0;
         packet_non_inc = 1'b0;
         param_position = '0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            expected_results.insert(expected_results.size(),
                                    decode_command(pending_commands[0].word,
                                                   pending_commands[0].left));
            void'(pending_commands.pop_front());
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_commands.size() != 0 &&
                      !(pending_commands[0].drain_first && expected_results.size() != 0)) begin
            req_tvalid <= 1'b1;
            req_tdata <= {4'b0, pending_commands[0].left, pending_commands[0].word};
            pending_commands[0].drain_first = 1'b0;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: ready follows changing stall modes, with one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         tick++;
         if (rsp_tvalid && rsp_tready)
            results_taken++;
         if (!long_hold_done && results_taken >= 300) begin
            long_hold_done = 1'b1;
            hold_left = 80;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (tick % 4 != 3);
               default: begin
                  if ($urandom_range(0, 15) == 0)
                     hold_left = $urandom_range(1, 16);
                  rsp_tready <= (hold_left == 0);
               end
            endcase
         end
      end
   end

   // Monitor: compares each result transaction with the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.jump_dest = rsp_tdata[31:0];
         got.method_addr = rsp_tdata[44:32];
         got.word_count = rsp_tdata[55:45];
         got.non_increment = rsp_tdata[56];
         got.param_data = rsp_tdata[88:57];
         got.param_index = rsp_tdata[99:89];
         got.packet_end = rsp_tlast;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result kind", 32'(got.kind), '0);
         end else begin
            want = expected_results.pop_front();
            if (got.kind != want.kind)
               report_mismatch("kind", 32'(got.kind), 32'(want.kind));
            if (got.jump_dest != want.jump_dest)
               report_mismatch("jump_dest", got.jump_dest, want.jump_dest);
            if (got.method_addr != want.method_addr)
               report_mismatch("method_addr", 32'(got.method_addr), 32'(want.method_addr));
            if (got.word_count != want.word_count)
               report_mismatch("word_count", 32'(got.word_count), 32'(want.word_count));
            if (got.non_increment != want.non_increment)
               report_mismatch("non_increment", 32'(got.non_increment),
                               32'(want.non_increment));
            if (got.param_data != want.param_data)
               report_mismatch("param_data", got.param_data, want.param_data);
            if (got.param_index != want.param_index)
               report_mismatch("param_index", 32'(got.param_index), 32'(want.param_index));
            if (got.packet_end != want.packet_end)
               report_mismatch("packet_end", 32'(got.packet_end), 32'(want.packet_end));
         end
      end
   end

   // Queues one command word.
   task automatic add_command(input logic [WordWidth-1:0] w, input logic [LeftWidth-1:0] left,
                              input bit drain_first);
      command_item_type c;
      c.word = w;
      c.left = left;
      c.drain_first = drain_first;
      pending_commands.insert(pending_commands.size(), c);
   endtask

   // Queues a method header with random fields, followed by its payload if it fits.
   task automatic add_packet(input int count, input int left, input bit drain_first);
      logic [WordWidth-1:0] hdr;
      hdr = $urandom;
      hdr[JumpBit] = 1'b0;
      hdr[PrefixLsb +: 2] = $urandom_range(0, 1) ? PREFIX_NON_INCREMENT : PREFIX_INCREMENT;
      hdr[CountLsb +: CountWidth] = count[CountWidth-1:0];
      add_command(hdr, left[LeftWidth-1:0], drain_first);
      if (count + 1 <= left) begin
         for (int i = 0; i < count; i++)
            add_command($urandom, 12'($urandom_range(1, 4095)), 1'b0);
      end
   endtask

   // Stimulus and end of run.
   initial begin
      int                   count;
      int                   pick;
      int                   made;
      logic [WordWidth-1:0] w;

      // Jumps, with bit 0 set under prefixes 11, 00 and 10.
      add_command(32'hFFFF_FFFF, 12'd4095, 1'b0);
      add_command(32'h0000_0001, 12'd1, 1'b0);
      add_command(32'h8000_0003, 12'd1, 1'b0);
      // Bad prefixes 01 and 11.
      add_command(32'h4000_0000, 12'd4095, 1'b0);
      add_command(32'hFFFF_FFFE, 12'd4095, 1'b0);
      // Empty packets, one with every other header bit set.
      add_command(32'h0000_0000, 12'd1, 1'b0);
      add_command(32'hA003_FFFE, 12'd1, 1'b0);
      // Truncated: largest count, and count equal to the words left.
      add_command(32'h9FFF_FFFC, 12'd2047, 1'b0);
      add_command(32'h200C_0004, 12'd3, 1'b0);
      // A packet that just fits, whose payload looks like jumps and errors.
      add_command(32'h200C_0004, 12'd4, 1'b0);
      add_command(32'hFFFF_FFFF, 12'd1, 1'b0);
      add_command(32'h0000_0001, 12'd4095, 1'b0);
      add_command(32'h4000_0000, 12'd1, 1'b0);
      // Single word packet with the largest method address.
      add_command(32'h0004_1FFC, 12'd4095, 1'b0);
      add_command(32'h0000_0000, 12'd4095, 1'b0);

      // One long packet, started on an empty pipeline.
      add_packet(511, 4095, 1'b1);

      // Random traffic, mostly well-formed packets, up to the planned total.
      made = 15 + 512;
      while (made < 1700) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            count = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 64);
            add_packet(count, $urandom_range(count + 1, 4095),
                       made == 527 || $urandom_range(0, 199) == 0);
            made += count + 1;
         end else if (pick < 80) begin
            add_command($urandom | 32'h1, 12'($urandom_range(1, 4095)), 1'b0);
            made++;
         end else if (pick < 88) begin
            w = $urandom;
            w[JumpBit] = 1'b0;
            w[PrefixLsb +: 2] = $urandom_range(0, 1) ? 2'b11 : 2'b01;
            add_command(w, 12'($urandom_range(1, 4095)), 1'b0);
            made++;
         end else begin
            count = $urandom_range(1, 64);
            add_packet(count, $urandom_range(1, count), 1'b0);
            made++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait for all commands to be taken and every result to be checked.
      while (pending_commands.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
